>>> hw/rtl/epoch_seconds_to_civil_date_macros.svh
// ============================================================================
// Assertion macros for the epoch seconds to civil date converter
// Shared concurrent assertion forms, clocked by clk and disabled during reset.
// ============================================================================
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ESCD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ESCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/escd_pkg.sv
// ============================================================================
// Epoch seconds to civil date package
// Widths, conversion constants, reciprocal multipliers and shared types.
// ============================================================================
package escd_pkg;

    localparam int IN_W   = 64;
    localparam int OUT_W  = 48;
    localparam int T_W    = 38;
    localparam int DAY_W  = 22;
    localparam int SOD_W  = 17;
    localparam int YEAR_W = 14;

    localparam logic [63:0] SECS_PER_DAY = 64'd86400;
    localparam logic [63:0] MAX_DAYS     = 64'd2932896;
    localparam logic [63:0] SAT_LIMIT    = (MAX_DAYS + 64'd1) * SECS_PER_DAY;
    localparam logic [T_W-1:0] SAT_T     = T_W'(SAT_LIMIT - 64'd1);

    // 86400 = 675 * 128, so the day split is a shift followed by a division by 675.
    localparam int DAY_LOW_W = 7;
    localparam int DAY_SHIFT = 41;
    localparam logic [63:0] DAY_DIV = 64'd675;
    localparam logic [31:0] DAY_MUL =
        32'(((64'd1 << DAY_SHIFT) + DAY_DIV - 64'd1) / DAY_DIV);

    localparam int HOUR_SHIFT = 29;
    localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
    localparam logic [17:0] HOUR_MUL =
        18'(((64'd1 << HOUR_SHIFT) + SECS_PER_HOUR - 64'd1) / SECS_PER_HOUR);

    localparam int MIN_SHIFT = 18;
    localparam logic [63:0] SECS_PER_MIN = 64'd60;
    localparam logic [12:0] MIN_MUL =
        13'(((64'd1 << MIN_SHIFT) + SECS_PER_MIN - 64'd1) / SECS_PER_MIN);

    localparam int WDAY_SHIFT = 25;
    localparam logic [63:0] DAYS_PER_WEEK = 64'd7;
    localparam logic [22:0] WDAY_MUL =
        23'(((64'd1 << WDAY_SHIFT) + DAYS_PER_WEEK - 64'd1) / DAYS_PER_WEEK);
    localparam logic [DAY_W-1:0] EPOCH_WDAY = 22'd4;

    localparam logic [DAY_W-1:0] MARCH_OFFSET = 22'd719468;
    localparam int YEAR_SHIFT = 49;
    localparam logic [63:0] DAYS_PER_400Y = 64'd146097;
    localparam logic [31:0] YEAR_MUL =
        32'(((64'd1 << YEAR_SHIFT) + DAYS_PER_400Y - 64'd1) / DAYS_PER_400Y);

    localparam int C100_SHIFT = 22;
    localparam logic [15:0] C100_MUL = 16'(((64'd1 << C100_SHIFT) + 64'd99) / 64'd100);

    localparam int MON_SHIFT = 21;
    localparam logic [8:0] MARCH_BASED_FEB = 9'd306;
    localparam logic [16:0] MON_MUL =
        17'(64'd10 * (((64'd1 << MON_SHIFT) + 64'd305) / 64'd306));

    typedef struct packed {
        logic [DAY_W-1:0] days;
        logic [SOD_W-1:0] sod;
    } day_split_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day_of_month;
    } date_t;

    // First day of a March-based month, as 367 * m / 12 - 30.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd61;
            4'd4:    off = 9'd92;
            4'd5:    off = 9'd122;
            4'd6:    off = 9'd153;
            4'd7:    off = 9'd184;
            4'd8:    off = 9'd214;
            4'd9:    off = 9'd245;
            4'd10:   off = 9'd275;
            4'd11:   off = 9'd306;
            4'd12:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> hw/rtl/escd_day_split.sv
// ============================================================================
// Day split front end
// Clamps the signed count and splits it into a day number and second of day.
// ============================================================================
`include "epoch_seconds_to_civil_date_macros.svh"

module escd_day_split (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [escd_pkg::IN_W-1:0]  epoch_seconds,
    output logic                       out_valid,
    output escd_pkg::day_split_t       out_split
);

    localparam int STAGES = 4;
    localparam int U_W    = escd_pkg::T_W - escd_pkg::DAY_LOW_W;

    logic [STAGES-1:0] vld_reg;

    logic [escd_pkg::T_W-1:0]       t_reg, t_next;
    logic [62:0]                    prod_reg, prod_next;
    logic [U_W-1:0]                 u2_reg, u2_next;
    logic [escd_pkg::DAY_LOW_W-1:0] low2_reg, low2_next;
    logic [escd_pkg::DAY_W-1:0]     days3_reg, days3_next;
    logic [U_W-1:0]                 u3_reg, u3_next;
    logic [escd_pkg::DAY_LOW_W-1:0] low3_reg, low3_next;
    logic [escd_pkg::DAY_W-1:0]     days4_reg, days4_next;
    logic [escd_pkg::SOD_W-1:0]     sod4_reg, sod4_next;
    logic                           over;
    logic [U_W-1:0]                 rem_full;

    always_comb
    begin
        over = (|epoch_seconds[62:escd_pkg::T_W])
            || (epoch_seconds[escd_pkg::T_W-1:0] >= escd_pkg::T_W'(escd_pkg::SAT_LIMIT));
        if (epoch_seconds[63])
        begin
            t_next = '0;
        end
        else if (over)
        begin
            t_next = escd_pkg::SAT_T;
        end
        else
        begin
            t_next = epoch_seconds[escd_pkg::T_W-1:0];
        end

        u2_next   = t_reg[escd_pkg::T_W-1:escd_pkg::DAY_LOW_W];
        low2_next = t_reg[escd_pkg::DAY_LOW_W-1:0];
        prod_next = 63'(u2_next) * 63'(escd_pkg::DAY_MUL);

        days3_next = prod_reg[62:escd_pkg::DAY_SHIFT];
        u3_next    = u2_reg;
        low3_next  = low2_reg;

        rem_full   = u3_reg - U_W'(days3_reg) * U_W'(escd_pkg::DAY_DIV);
        days4_next = days3_reg;
        sod4_next  = {rem_full[9:0], low3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            prod_reg  <= prod_next;
            u2_reg    <= u2_next;
            low2_reg  <= low2_next;
            days3_reg <= days3_next;
            u3_reg    <= u3_next;
            low3_reg  <= low3_next;
            days4_reg <= days4_next;
            sod4_reg  <= sod4_next;
        end
    end

    assign out_valid      = vld_reg[STAGES-1];
    assign out_split.days = days4_reg;
    assign out_split.sod  = sod4_reg;

    `ESCD_ASSERT_IMPLY(a_split_range, out_valid,
        (sod4_reg < escd_pkg::SOD_W'(escd_pkg::SECS_PER_DAY))
        && (days4_reg <= escd_pkg::DAY_W'(escd_pkg::MAX_DAYS)),
        "day split out of range")

endmodule

>>> hw/rtl/escd_time_of_day.sv
// ============================================================================
// Time of day and weekday path
// Derives hour, minute, second and weekday from the day split.
// ============================================================================
`include "epoch_seconds_to_civil_date_macros.svh"

module escd_time_of_day (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  escd_pkg::day_split_t  in_split,
    output logic                  out_valid,
    output escd_pkg::tod_t        out_tod
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] vld_reg;

    logic [34:0]                hp_reg, hp_next;
    logic [44:0]                wp_reg, wp_next;
    logic [escd_pkg::DAY_W-1:0] x4_reg, x4_next;
    logic [escd_pkg::SOD_W-1:0] sod5_reg, sod5_next;

    logic [4:0]                 hour6_reg, hour6_next;
    logic [2:0]                 wday6_reg, wday6_next;
    logic [escd_pkg::SOD_W-1:0] sod6_reg, sod6_next;

    logic [11:0] rem7_reg, rem7_next;
    logic [4:0]  hour7_reg;
    logic [2:0]  wday7_reg;

    logic [24:0] mnp8_reg, mnp8_next;
    logic [11:0] rem8_reg;
    logic [4:0]  hour8_reg;
    logic [2:0]  wday8_reg;

    logic [5:0]  min9_reg, min9_next;
    logic [11:0] rem9_reg;
    logic [4:0]  hour9_reg;
    logic [2:0]  wday9_reg;

    escd_pkg::tod_t tod10_reg, tod10_next;
    escd_pkg::tod_t tod11_reg;
    escd_pkg::tod_t tod12_reg;

    logic [19:0]                q7;
    logic [escd_pkg::DAY_W-1:0] wrem;
    logic [11:0]                sec_full;

    always_comb
    begin
        x4_next   = in_split.days + escd_pkg::EPOCH_WDAY;
        sod5_next = in_split.sod;
        hp_next   = 35'(in_split.sod) * 35'(escd_pkg::HOUR_MUL);
        wp_next   = 45'(x4_next) * 45'(escd_pkg::WDAY_MUL);

        q7         = wp_reg[44:escd_pkg::WDAY_SHIFT];
        wrem       = x4_reg - escd_pkg::DAY_W'(q7) * escd_pkg::DAY_W'(escd_pkg::DAYS_PER_WEEK);
        wday6_next = wrem[2:0];
        hour6_next = hp_reg[escd_pkg::HOUR_SHIFT+4:escd_pkg::HOUR_SHIFT];
        sod6_next  = sod5_reg;

        rem7_next = 12'(sod6_reg - escd_pkg::SOD_W'(hour6_reg)
                    * escd_pkg::SOD_W'(escd_pkg::SECS_PER_HOUR));

        mnp8_next = 25'(rem7_reg) * 25'(escd_pkg::MIN_MUL);

        min9_next = mnp8_reg[escd_pkg::MIN_SHIFT+5:escd_pkg::MIN_SHIFT];

        sec_full           = rem9_reg - 12'(min9_reg) * 12'(escd_pkg::SECS_PER_MIN);
        tod10_next.second  = sec_full[5:0];
        tod10_next.minute  = min9_reg;
        tod10_next.hour    = hour9_reg;
        tod10_next.weekday = wday9_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg    <= hp_next;
            wp_reg    <= wp_next;
            x4_reg    <= x4_next;
            sod5_reg  <= sod5_next;
            hour6_reg <= hour6_next;
            wday6_reg <= wday6_next;
            sod6_reg  <= sod6_next;
            rem7_reg  <= rem7_next;
            hour7_reg <= hour6_reg;
            wday7_reg <= wday6_reg;
            mnp8_reg  <= mnp8_next;
            rem8_reg  <= rem7_reg;
            hour8_reg <= hour7_reg;
            wday8_reg <= wday7_reg;
            min9_reg  <= min9_next;
            rem9_reg  <= rem8_reg;
            hour9_reg <= hour8_reg;
            wday9_reg <= wday8_reg;
            tod10_reg <= tod10_next;
            tod11_reg <= tod10_reg;
            tod12_reg <= tod11_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_tod   = tod12_reg;

    `ESCD_ASSERT_IMPLY(a_tod_range, out_valid,
        (tod12_reg.hour < 5'd24) && (tod12_reg.minute < 6'd60)
        && (tod12_reg.second < 6'd60) && (tod12_reg.weekday < 3'd7),
        "time of day out of range")

endmodule

>>> hw/rtl/escd_calendar.sv
// ============================================================================
// Calendar date path
// Converts the day number to year, month and day of month through a
// March-based year estimate with a one-step correction.
// ============================================================================
`include "epoch_seconds_to_civil_date_macros.svh"

module escd_calendar (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  escd_pkg::day_split_t  in_split,
    output logic                  out_valid,
    output escd_pkg::date_t       out_date
);

    localparam int STAGES = 8;
    localparam int YW     = escd_pkg::YEAR_W;

    logic [STAGES-1:0] vld_reg;

    logic [escd_pkg::DAY_W-1:0] d5_reg, d5_next;
    logic [30:0]                n5_reg, n5_next;
    logic [escd_pkg::DAY_W-1:0] d6_reg;
    logic [62:0]                yp6_reg, yp6_next;
    logic [escd_pkg::DAY_W-1:0] d7_reg;
    logic [YW-1:0]              y7_reg, y7_next;
    logic [escd_pkg::DAY_W-1:0] d8_reg;
    logic [YW-1:0]              y8_reg;
    logic [29:0]                c8_reg, c8_next;
    logic [22:0]                base8_reg, base8_next;
    logic [YW-1:0]              y9_reg;
    logic signed [10:0]         yday9_reg, yday9_next;
    logic                       leap9_reg, leap9_next;
    logic [8:0]                 yd10_reg, yd10_next;
    logic [YW-1:0]              yr10_reg, yr10_next;
    logic [8:0]                 yd11_reg;
    logic [YW-1:0]              yr11_reg;
    logic [3:0]                 mon11_reg, mon11_next;
    escd_pkg::date_t            date12_reg, date12_next;

    logic [escd_pkg::DAY_W-1:0] dp2;
    logic [7:0]                 h;
    logic [23:0]                ydw;
    logic [25:0]                mprod;
    logic [8:0]                 mday_full;

    always_comb
    begin
        d5_next = in_split.days + escd_pkg::MARCH_OFFSET;
        dp2     = d5_next + escd_pkg::DAY_W'(2);
        n5_next = 31'(dp2) * 31'd400;

        yp6_next = 63'(n5_reg) * 63'(escd_pkg::YEAR_MUL);

        y7_next = yp6_reg[62:escd_pkg::YEAR_SHIFT];

        c8_next    = 30'(y7_reg) * 30'(escd_pkg::C100_MUL);
        base8_next = 23'(y7_reg) * 23'd365 + 23'(y7_reg[YW-1:2]);

        h          = c8_reg[29:escd_pkg::C100_SHIFT];
        ydw        = 24'(d8_reg) - 24'(base8_reg) + 24'(h) - 24'(h[7:2]);
        yday9_next = ydw[10:0];
        leap9_next = (y8_reg[1:0] == 2'b00)
                  && ((y8_reg != YW'(h) * YW'(100)) || (h[1:0] == 2'b00));

        if (yday9_reg[10])
        begin
            yd10_next = 9'(11'(yday9_reg) + 11'd365 + 11'(leap9_reg));
            yr10_next = y9_reg - YW'(1);
        end
        else
        begin
            yd10_next = 9'(yday9_reg);
            yr10_next = y9_reg;
        end

        mprod      = 26'(yd10_reg + 9'd31) * 26'(escd_pkg::MON_MUL);
        mon11_next = mprod[escd_pkg::MON_SHIFT+3:escd_pkg::MON_SHIFT];

        mday_full                = yd11_reg - escd_pkg::month_offset(mon11_reg) + 9'd1;
        date12_next.day_of_month = mday_full[4:0];
        if (yd11_reg >= escd_pkg::MARCH_BASED_FEB)
        begin
            date12_next.year  = yr11_reg + YW'(1);
            date12_next.month = mon11_reg - 4'd10;
        end
        else
        begin
            date12_next.year  = yr11_reg;
            date12_next.month = mon11_reg + 4'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d5_reg     <= d5_next;
            n5_reg     <= n5_next;
            d6_reg     <= d5_reg;
            yp6_reg    <= yp6_next;
            d7_reg     <= d6_reg;
            y7_reg     <= y7_next;
            d8_reg     <= d7_reg;
            y8_reg     <= y7_reg;
            c8_reg     <= c8_next;
            base8_reg  <= base8_next;
            y9_reg     <= y8_reg;
            yday9_reg  <= yday9_next;
            leap9_reg  <= leap9_next;
            yd10_reg   <= yd10_next;
            yr10_reg   <= yr10_next;
            yd11_reg   <= yd10_reg;
            yr11_reg   <= yr10_reg;
            mon11_reg  <= mon11_next;
            date12_reg <= date12_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_date  = date12_reg;

    `ESCD_ASSERT_IMPLY(a_date_range, out_valid,
        (date12_reg.month >= 4'd1) && (date12_reg.month <= 4'd12)
        && (date12_reg.day_of_month >= 5'd1)
        && (date12_reg.year >= YW'(1970)) && (date12_reg.year <= YW'(9999)),
        "calendar date out of range")

endmodule

>>> hw/rtl/epoch_seconds_to_civil_date.sv
// ============================================================================
// Epoch seconds to civil date converter
// Turns a signed count of seconds since 1970-01-01 UTC into calendar fields.
// ============================================================================
// Input stream: one 64-bit signed second count per transaction on s_tdata.
// Negative counts give 1970-01-01 00:00:00; counts past 9999-12-31 23:59:59
// give that instant.
// Output stream: one transaction per input with second, minute, hour, day of
// month, month, year and weekday (Sunday is 0) packed into m_tdata.
// The pipeline has 12 register stages. Four stages split the count into days
// and second of day, then eight stages run the time of day and the calendar
// date side by side. No stage chains more than one multiply.
// Throughput is one transaction per cycle while m_tready is high.
// When the receiver stalls, the whole pipeline holds and s_tready drops
// until the output transaction is taken; nothing is dropped or repeated.
// Reset empties the pipeline; no output is valid until new input arrives.
// ============================================================================
`include "epoch_seconds_to_civil_date_macros.svh"

module epoch_seconds_to_civil_date (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [escd_pkg::IN_W-1:0]  s_tdata,  // [63:0] epoch_seconds
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
    // [25:22] month, [39:26] year, [42:40] weekday, [47:43] zero
    output logic [escd_pkg::OUT_W-1:0] m_tdata
);

    logic                 en;
    logic                 split_valid;
    escd_pkg::day_split_t split;
    logic                 tod_valid;
    escd_pkg::tod_t       tod;
    logic                 date_valid;
    escd_pkg::date_t      date;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    escd_day_split u_day_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .epoch_seconds (s_tdata),
        .out_valid     (split_valid),
        .out_split     (split)
    );

    escd_time_of_day u_time_of_day (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (split_valid),
        .in_split  (split),
        .out_valid (tod_valid),
        .out_tod   (tod)
    );

    escd_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (split_valid),
        .in_split  (split),
        .out_valid (date_valid),
        .out_date  (date)
    );

    assign m_tvalid = date_valid;
    assign m_tdata  = {5'd0, tod.weekday, date.year, date.month, date.day_of_month,
                       tod.hour, tod.minute, tod.second};

    `ESCD_ASSERT_ALWAYS(a_paths_aligned, tod_valid == date_valid,
        "time and date paths out of step")

    `ESCD_ASSERT_IMPLY(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "input taken while output stalled")

endmodule
